// ===== sv/seq_pkg.sv =====
`timescale 1ns / 1ps

package seq_pkg;

  localparam int SLOTS  = 64;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(SLOTS);

  localparam int SLOT_W   = 6;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // s_axis_tdata: slot, key
  localparam int S_DATA_W = 40;
  // m_axis_tdata: head_valid, head_slot, head_key, entry_count
  localparam int M_DATA_W = 48;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE           = 2'd0,
    STAT_REMOVE_ABSENT  = 2'd1,
    STAT_INSERT_PRESENT = 2'd2
  } status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    status_t             status;
    logic                head_valid;
    logic [SLOT_W-1:0]   head_slot;
    logic [KEY_W-1:0]    head_key;
    logic [COUNT_W-1:0]  entry_count;
  } result_t;

endpackage

// ===== sv/seq_ram.sv =====
`timescale 1ns / 1ps

module seq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/seq_ctrl.sv =====
`timescale 1ns / 1ps

module seq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_mode,
  input  logic [seq_pkg::SLOT_W-1:0] in_slot,
  input  logic [seq_pkg::KEY_W-1:0]  in_key,
  output logic                       res_valid,
  input  logic                       res_ready,
  output seq_pkg::result_t           res
);

  import seq_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WALK  = 7'b0000010,
    ST_LINK1 = 7'b0000100,
    ST_LINK2 = 7'b0001000,
    ST_RLINK = 7'b0010000,
    ST_HKEY  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t              state, state_next;
  logic                op_mode;
  logic [IDX_W-1:0]    op_slot;
  logic [KEY_W-1:0]    op_key;
  status_t             op_status;
  logic [LINK_W-1:0]   cur, prev;
  logic [LINK_W-1:0]   head_link;
  logic [KEY_W-1:0]    head_key;
  logic [COUNT_W-1:0]  count;
  logic [SLOTS-1:0]    in_list;

  logic [IDX_W-1:0]    in_idx;
  logic [IDX_W-1:0]    rd_addr;
  logic [LINK_W-1:0]   next_rd;
  logic [KEY_W-1:0]    key_rd;
  logic                next_we, key_we;
  logic [IDX_W-1:0]    next_waddr;
  logic [LINK_W-1:0]   next_wdata;
  logic                advance;

  assign in_idx = in_slot[IDX_W-1:0];

  // successor links and keys, one read address shared by both
  seq_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (next_rd)
  );

  seq_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (op_slot),
    .wdata (op_key),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  // shared compare unit: keep walking past lower keys or past other slots
  always_comb begin
    if (op_mode == OP_INSERT) begin
      advance = $signed(key_rd) < $signed(op_key);
    end else begin
      advance = cur[IDX_W-1:0] != op_slot;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = cur[IDX_W-1:0];
    next_we    = 1'b0;
    next_waddr = op_slot;
    next_wdata = cur;
    key_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        rd_addr = head_link[IDX_W-1:0];
        if (in_valid) begin
          if (in_mode == OP_INSERT) begin
            if (in_list[in_idx]) begin
              state_next = ST_FIN;
            end else if (head_link == LINK_NULL) begin
              state_next = ST_LINK1;
            end else begin
              state_next = ST_WALK;
            end
          end else begin
            state_next = in_list[in_idx] ? ST_WALK : ST_FIN;
          end
        end
      end
      ST_WALK: begin
        if (advance) begin
          rd_addr = next_rd[IDX_W-1:0];
          if (next_rd == LINK_NULL) begin
            state_next = ST_LINK1;
          end
        end else begin
          state_next = (op_mode == OP_INSERT) ? ST_LINK1 : ST_RLINK;
        end
      end
      ST_LINK1: begin
        next_we    = 1'b1;
        key_we     = 1'b1;
        state_next = (prev == LINK_NULL) ? ST_FIN : ST_LINK2;
      end
      ST_LINK2: begin
        next_we    = 1'b1;
        next_waddr = prev[IDX_W-1:0];
        next_wdata = LINK_W'(op_slot);
        state_next = ST_FIN;
      end
      ST_RLINK: begin
        if (prev != LINK_NULL) begin
          next_we    = 1'b1;
          next_waddr = prev[IDX_W-1:0];
          next_wdata = cur;
          state_next = ST_FIN;
        end else begin
          state_next = (cur == LINK_NULL) ? ST_FIN : ST_HKEY;
        end
      end
      ST_HKEY: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head_link <= LINK_NULL;
      count     <= '0;
      in_list   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_LINK1: begin
          in_list[op_slot] <= 1'b1;
          count            <= count + COUNT_W'(1);
          if (prev == LINK_NULL) begin
            head_link <= LINK_W'(op_slot);
          end
        end
        ST_RLINK: begin
          in_list[op_slot] <= 1'b0;
          count            <= count - COUNT_W'(1);
          if (prev == LINK_NULL) begin
            head_link <= cur;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_mode <= in_mode;
          op_slot <= in_idx;
          op_key  <= in_key;
          cur     <= head_link;
          prev    <= LINK_NULL;
          if (in_mode == OP_INSERT) begin
            op_status <= in_list[in_idx] ? STAT_INSERT_PRESENT : STAT_DONE;
          end else begin
            op_status <= in_list[in_idx] ? STAT_DONE : STAT_REMOVE_ABSENT;
          end
        end
      end
      ST_WALK: begin
        if (advance) begin
          prev <= cur;
          cur  <= next_rd;
        end else if (op_mode == OP_REMOVE) begin
          cur <= next_rd;
        end
      end
      ST_LINK1: begin
        if (prev == LINK_NULL) begin
          head_key <= op_key;
        end
      end
      ST_HKEY: begin
        head_key <= key_rd;
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = state == ST_IDLE;
  assign res_valid = state == ST_FIN;

  always_comb begin
    res.status      = op_status;
    res.head_valid  = head_link != LINK_NULL;
    res.head_slot   = res.head_valid ? SLOT_W'(head_link[IDX_W-1:0]) : '0;
    res.head_key    = res.head_valid ? head_key : '0;
    res.entry_count = count;
  end

endmodule

// ===== sv/sorted_event_queue.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Beat                                  Fields, lowest bit up
// s_axis   in   one insert or remove request          tuser: mode; tdata: slot, key
// m_axis   out  one result per accepted request       tuser: status; tdata: head_valid,
//                                                     head_slot, head_key, entry_count
//
// An item takes the sequencer through accept, one step per list entry the walk reads (one
// read of the link/key memories per step), one or two link writes or a head unlink with
// key fetch if any remain, and the result step. A refused request skips walk and writes.
// Reset clears the membership bits, head and count; link and key memories need no clear.
// s_axis_tready is high only while the sequencer is idle; a result that waits in the
// output register holds the sequencer in its last step, not the next accept.

module sorted_event_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [seq_pkg::S_DATA_W-1:0]  s_axis_tdata,  // slot[5:0], key[37:6], zero pad
  input  logic                          s_axis_tuser,  // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [seq_pkg::M_DATA_W-1:0]  m_axis_tdata,  // head_valid[0], head_slot[6:1],
                                                       // head_key[38:7], entry_count[45:39]
  output logic [seq_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);

  import seq_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  seq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .in_slot   (s_axis_tdata[SLOT_W-1:0]),
    .in_key    (s_axis_tdata[SLOT_W +: KEY_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: takes the result when empty or draining this cycle
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {
    2'b00,
    out_res.entry_count,
    out_res.head_key,
    out_res.head_slot,
    out_res.head_valid
  };

endmodule

// ===== sv/seq_checker.sv =====
`timescale 1ns / 1ps

module seq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [seq_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [seq_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input logic [seq_pkg::STATUS_W-1:0]  m_axis_tuser
);

  import seq_pkg::*;

  logic [COUNT_W-1:0] cnt;
  assign cnt = m_axis_tdata[45:39];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("unknown status code");

  a_head_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[0] == (cnt != '0))
    else $error("head_valid disagrees with entry_count");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[38:1] == '0)
    else $error("empty list shows a head");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> cnt <= COUNT_W'(SLOTS))
    else $error("entry_count above slot count");

endmodule

bind sorted_event_queue seq_checker u_seq_checker (.*);

// ===== bench/sorted_event_queue_tb.sv =====
`timescale 1ns / 1ps

module sorted_event_queue_tb;
  import seq_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RESET_TICKS = 5;
  localparam int RAND_OPS    = 500;
  localparam int PHASE_LEN   = 60;
  // worst item: a full walk of 64 entries plus setup, with both sides idling between beats
  localparam int DRAIN_TICKS = 100;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic               mode;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   key;
  } event_op_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_DATA_W-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;

  sorted_event_queue dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the linked list: successor links, keys, membership, head, count.
  // Links and keys of unlinked slots are never read, so they need no reset.
  // ---------------------------------------------------------------------------
  logic [LINK_W-1:0]        next_of [SLOTS];
  logic signed [KEY_W-1:0]  key_of  [SLOTS];
  logic                     linked  [SLOTS];
  logic [LINK_W-1:0]        front_slot = LINK_NULL;
  int                       depth = 0;

  result_t   queue_snapshots [$];   // expected result per accepted beat, oldest first
  event_op_t pending_ops [$];       // request beats not yet presented

  int error_count   = 0;
  int accepted_ops  = 0;
  int checked_beats = 0;
  int insert_ops    = 0;
  int remove_ops    = 0;
  int refused_ops   = 0;
  int peak_depth    = 0;
  int cycle_count   = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) linked[i] = 1'b0;
  end

  // Apply one request to the shadow list and return the result it must produce.
  function automatic result_t apply_event_op(logic mode, logic [SLOT_W-1:0] slot,
                                             logic signed [KEY_W-1:0] key);
    result_t           res;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] cur;
    res = '0;
    res.status = STAT_DONE;
    prev = LINK_NULL;
    cur  = front_slot;
    if (mode == OP_INSERT) begin
      insert_ops++;
      if (linked[slot]) begin
        res.status = STAT_INSERT_PRESENT;
      end else begin
        // stop at the first entry whose key is >= the new one: newest tie goes first
        while (cur != LINK_NULL && key_of[cur] < key) begin
          prev = cur;
          cur  = next_of[cur];
        end
        key_of[slot] = key;
        if (prev != LINK_NULL) begin
          next_of[slot] = next_of[prev];
          next_of[prev] = LINK_W'(slot);
        end else begin
          next_of[slot] = front_slot;
          front_slot    = LINK_W'(slot);
        end
        linked[slot] = 1'b1;
        depth++;
      end
    end else begin
      remove_ops++;
      if (!linked[slot]) begin
        res.status = STAT_REMOVE_ABSENT;
      end else begin
        while (cur != LINK_NULL && cur != LINK_W'(slot)) begin
          prev = cur;
          cur  = next_of[cur];
        end
        if (prev != LINK_NULL) next_of[prev] = next_of[slot];
        else front_slot = next_of[slot];
        linked[slot] = 1'b0;
        depth--;
      end
    end
    if (res.status != STAT_DONE) refused_ops++;
    if (depth > peak_depth) peak_depth = depth;
    if (front_slot != LINK_NULL) begin
      res.head_valid = 1'b1;
      res.head_slot  = front_slot[SLOT_W-1:0];
      res.head_key   = key_of[front_slot];
    end
    res.entry_count = COUNT_W'(depth);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus build. gen_linked tracks membership as the request list grows so
  // the random part can aim at valid slots most of the time.
  // ---------------------------------------------------------------------------
  logic gen_linked [SLOTS];

  function automatic void push_op(logic mode, int slot, logic [KEY_W-1:0] key);
    event_op_t op;
    op.mode = mode;
    op.slot = SLOT_W'(slot);
    op.key  = key;
    pending_ops.push_back(op);
    if (mode == OP_INSERT) gen_linked[slot] = 1'b1;
    else gen_linked[slot] = 1'b0;
  endfunction

  // Random slot that is (want == 1) or is not linked; any slot if none qualifies.
  function automatic int pick_slot(logic want);
    int hits [$];
    for (int i = 0; i < SLOTS; i++)
      if (gen_linked[i] == want) hits.push_back(i);
    if (hits.size() == 0) return $urandom_range(0, SLOTS - 1);
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom();
    if (sel < 70) return KEY_W'($signed($urandom_range(0, 8)) - 4);  // dense ties
    if (sel < 85) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return KEY_W'($signed($urandom_range(0, 255)) - 128);
  endfunction

  task automatic build_stimulus();
    int fill_pct;
    int noise;
    for (int i = 0; i < SLOTS; i++) gen_linked[i] = 1'b0;

    // directed: empty-list remove, key extremes, ties at 0/min/max,
    // duplicate insert, head/middle/tail removes, drain back to empty
    push_op(OP_REMOVE, 5, $urandom());
    push_op(OP_INSERT, 0, 32'h0000_0000);
    push_op(OP_INSERT, 63, 32'h7fff_ffff);
    push_op(OP_INSERT, 1, 32'h8000_0000);
    push_op(OP_INSERT, 2, 32'h0000_0000);
    push_op(OP_INSERT, 3, 32'h0000_0000);
    push_op(OP_INSERT, 0, 32'h0000_0005);
    push_op(OP_INSERT, 4, 32'hffff_ffff);
    push_op(OP_REMOVE, 2, $urandom());
    push_op(OP_REMOVE, 1, $urandom());
    push_op(OP_REMOVE, 63, $urandom());
    push_op(OP_REMOVE, 63, $urandom());
    push_op(OP_INSERT, 63, 32'h7fff_ffff);
    push_op(OP_INSERT, 42, 32'h7fff_ffff);
    push_op(OP_INSERT, 21, 32'h8000_0000);
    push_op(OP_INSERT, 22, 32'h8000_0000);
    push_op(OP_REMOVE, 4, 32'hffff_ffff);
    push_op(OP_REMOVE, 3, $urandom());
    push_op(OP_REMOVE, 0, $urandom());
    push_op(OP_REMOVE, 21, $urandom());
    push_op(OP_REMOVE, 22, $urandom());
    push_op(OP_REMOVE, 42, $urandom());
    push_op(OP_REMOVE, 63, $urandom());

    // random: alternating fill and drain phases; the second fill is the heaviest.
    // A few percent are deliberately refused ops.
    for (int n = 0; n < RAND_OPS; n++) begin
      case ((n / PHASE_LEN) % 4)
        0: fill_pct = 85;
        1: fill_pct = 20;
        2: fill_pct = 97;
        default: fill_pct = 10;
      endcase
      noise = ($urandom_range(0, 99) < 8);
      if ($urandom_range(0, 99) < fill_pct)
        push_op(OP_INSERT, pick_slot(noise ? 1'b1 : 1'b0), pick_key());
      else
        push_op(OP_REMOVE, pick_slot(noise ? 1'b0 : 1'b1), $urandom());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: holds each beat until accepted, then may wait before the next.
  // Every third block of 50 beats runs back to back with no gaps.
  // ---------------------------------------------------------------------------
  int        gap_left = 0;
  event_op_t next_op;

  function automatic int draw_gap(int beat_no);
    if ((beat_no / 50) % 3 == 2) return 0;
    return $urandom_range(0, 6);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      queue_snapshots.push_back(apply_event_op(s_axis_tuser, s_axis_tdata[SLOT_W-1:0],
                                               s_axis_tdata[SLOT_W +: KEY_W]));
      accepted_ops++;
      gap_left = draw_gap(accepted_ops);
      if (gap_left == 0 && pending_ops.size() > 0) begin
        // back-to-back: valid stays high, only the payload moves on
        next_op = pending_ops.pop_front();
        s_axis_tuser <= next_op.mode;
        s_axis_tdata <= {2'b00, next_op.key, next_op.slot};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end else if (!s_axis_tvalid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        next_op = pending_ops.pop_front();
        s_axis_tuser  <= next_op.mode;
        s_axis_tdata  <= {2'b00, next_op.key, next_op.slot};
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each beat against the oldest snapshot, then may
  // drop ready before taking the next beat.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: beat %0d %s mismatch, expected 0x%0h, got 0x%0h",
               $time, checked_beats, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (queue_snapshots.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got tuser 0x%0h tdata 0x%0h",
                 $time, m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        want = queue_snapshots.pop_front();
        check_field("status",      KEY_W'(want.status),      KEY_W'(m_axis_tuser));
        check_field("head_valid",  KEY_W'(want.head_valid),  KEY_W'(m_axis_tdata[0]));
        check_field("head_slot",   KEY_W'(want.head_slot),   KEY_W'(m_axis_tdata[6:1]));
        check_field("head_key",    want.head_key,            m_axis_tdata[38:7]);
        check_field("entry_count", KEY_W'(want.entry_count), KEY_W'(m_axis_tdata[45:39]));
      end
      checked_beats++;
      stall_left = ((checked_beats / 40) % 3 == 1) ? 0 : $urandom_range(0, 6);
      if (stall_left != 0) m_axis_tready <= 1'b0;
    end else if (!m_axis_tready) begin
      if (stall_left > 0) stall_left--;
      else m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, queue_snapshots.size());
      $display("[sorted_event_queue] ERROR");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;
    while (pending_ops.size() > 0 || s_axis_tvalid || queue_snapshots.size() > 0)
      @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
    if (queue_snapshots.size() != 0 || pending_ops.size() != 0) begin
      $display("%0t: results missing, expected %0d more beats, got none",
               $time, queue_snapshots.size() + pending_ops.size());
      error_count++;
    end
    $display("%0d requests (%0d inserts, %0d removes, %0d refused), %0d results checked",
             accepted_ops, insert_ops, remove_ops, refused_ops, checked_beats);
    $display("peak list depth %0d of %0d slots, %0d mismatches",
             peak_depth, SLOTS, error_count);
    if (error_count == 0) begin
      $display("[sorted_event_queue] OK");
    end else begin
      $display("[sorted_event_queue] ERROR");
    end
    $finish;
  end

endmodule

// ===== sorted_event_queue.f =====
sv/seq_pkg.sv
sv/seq_ram.sv
sv/seq_ctrl.sv
sv/sorted_event_queue.sv
sv/seq_checker.sv
bench/sorted_event_queue_tb.sv
